>>> hw/rtl/assert_macros.svh
// Assertion macros used by the RTL of the nearest waypoint search unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define NWS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Checked on every rising edge, reset included.
`define NWS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

>>> hw/rtl/nws_pkg.sv
// Package with the shared types and constants of the nearest waypoint search unit.
`timescale 1ns / 1ps

package nws_pkg;

    // Field widths
    localparam int COORD_W = 24;
    localparam int IDX_W   = 5;
    localparam int PLEN_W  = 6;
    localparam int SQ_W    = 48;
    localparam int DIST_W  = 50;

    // Command codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Configuration port
    localparam int   ADDR_W       = 3;
    localparam int   PDATA_W      = 32;
    localparam logic REG_PATH_LEN = 1'b0;

    // One 3D point in Q16.8 meters
    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } t_xyz;

    // Waypoint write broadcast to the cells
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        t_xyz             pt;
    } t_wr;

    // Running best carried from cell to cell
    typedef struct packed {
        logic              vld;
        logic              have;
        logic [IDX_W-1:0]  idx;
        logic [DIST_W-1:0] dsq;
    } t_tok;

endpackage

>>> hw/rtl/nws_req_if.sv
// Request channel: waypoint writes and nearest waypoint queries.
`timescale 1ns / 1ps

interface nws_req_if;
    logic                              valid;
    logic                              ready;
    logic                              cmd;
    logic [nws_pkg::IDX_W-1:0]         entry_index;
    logic signed [nws_pkg::COORD_W-1:0] coord_x;
    logic signed [nws_pkg::COORD_W-1:0] coord_y;
    logic signed [nws_pkg::COORD_W-1:0] coord_z;

    modport source (output valid, cmd, entry_index, coord_x, coord_y, coord_z,
                    input ready);
    modport sink   (input valid, cmd, entry_index, coord_x, coord_y, coord_z,
                    output ready);
endinterface

>>> hw/rtl/nws_rsp_if.sv
// Response channel: index of the nearest waypoint.
`timescale 1ns / 1ps

interface nws_rsp_if;
    logic                      valid;
    logic                      ready;
    logic [nws_pkg::IDX_W-1:0] nearest_index;
    logic                      found;

    modport source (output valid, nearest_index, found, input ready);
    modport sink   (input valid, nearest_index, found, output ready);
endinterface

>>> hw/rtl/nws_cell.sv
// One search cell: holds a waypoint, computes its distance, updates the passing best.
`timescale 1ns / 1ps

module nws_cell #(
    parameter int ID = 0
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  nws_pkg::t_wr                i_wr,
    input  nws_pkg::t_xyz               i_pos,
    input  logic [nws_pkg::PLEN_W-1:0]  i_path_len,
    input  nws_pkg::t_tok               i_tok,
    output nws_pkg::t_tok               o_tok
);

    localparam int IDB = $clog2(ID + 1);
    localparam int CW  = (IDB > nws_pkg::PLEN_W) ? IDB : nws_pkg::PLEN_W;
    localparam int IW  = (IDB > nws_pkg::IDX_W) ? IDB : nws_pkg::IDX_W;

    nws_pkg::t_xyz               r_wp;
    logic [nws_pkg::SQ_W-1:0]    r_sq_x, r_sq_y, r_sq_z;
    logic [nws_pkg::SQ_W-1:0]    n_sq_x, n_sq_y, n_sq_z;
    logic [nws_pkg::DIST_W-1:0]  r_dist;
    nws_pkg::t_tok               r_tok, n_tok;
    logic signed [24:0]          w_dx, w_dy, w_dz;
    logic signed [49:0]          w_px, w_py, w_pz;
    logic                        w_active;

    // Waypoint load on a matching write
    always_ff @(posedge i_clk) begin
        if (i_wr.en && (IW'(i_wr.idx) == IW'(ID))) begin
            r_wp <= i_wr.pt;
        end
    end

    // Stage 1: per-axis differences and squares
    always_comb begin
        w_dx   = $signed({r_wp.x[23], r_wp.x}) - $signed({i_pos.x[23], i_pos.x});
        w_dy   = $signed({r_wp.y[23], r_wp.y}) - $signed({i_pos.y[23], i_pos.y});
        w_dz   = $signed({r_wp.z[23], r_wp.z}) - $signed({i_pos.z[23], i_pos.z});
        w_px   = w_dx * w_dx;
        w_py   = w_dy * w_dy;
        w_pz   = w_dz * w_dz;
        n_sq_x = w_px[nws_pkg::SQ_W-1:0];
        n_sq_y = w_py[nws_pkg::SQ_W-1:0];
        n_sq_z = w_pz[nws_pkg::SQ_W-1:0];
    end

    // Stage 2: squared distance
    always_ff @(posedge i_clk) begin
        r_sq_x <= n_sq_x;
        r_sq_y <= n_sq_y;
        r_sq_z <= n_sq_z;
        r_dist <= {2'b00, r_sq_x} + {2'b00, r_sq_y} + {2'b00, r_sq_z};
    end

    // Compare against the incoming best; strict less-than keeps the lower index
    assign w_active = CW'(ID) < CW'(i_path_len);

    always_comb begin
        n_tok = i_tok;
        if (i_tok.vld && w_active && (!i_tok.have || (r_dist < i_tok.dsq))) begin
            n_tok.have = 1'b1;
            n_tok.idx  = nws_pkg::IDX_W'(ID);
            n_tok.dsq  = r_dist;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.vld <= 1'b0;
        end else begin
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

>>> hw/rtl/nearest_waypoint_search_unit.sv
// Top level of the nearest waypoint search unit: control, config port and the cell row.
//
// Request words on i_req carry cmd, entry_index and a Q16.8 point. A write word
// (cmd 0) loads waypoint entry_index into its cell and gives no response.
// A query word (cmd 1) returns one response word on o_rsp: the index of the stored
// waypoint nearest to the point among the first path_length entries, lowest index
// on ties, and found=0 with index 0 when path_length is zero.
// path_length sits at APB address 0; writes take setup and access, pready stays high.
// A query response follows acceptance through the squares and distance registers in
// every cell; then the running best moves one cell per cycle along a row of
// MAX_WAYPOINTS cells into the holding register and on to the response register.
// A write leaves the unit idle, so it never holds off the next request.
// Requests are taken only while no query is in flight; a finished response waits in
// a holding register while the response register is still full, and a new request
// may be taken while the response register waits on a stalled receiver.
// Reset (synchronous, active low) empties the row and the response register and
// sets path_length to 0; waypoint contents are undefined until written.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module nearest_waypoint_search_unit #(
    parameter int MAX_WAYPOINTS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    nws_req_if.sink                       i_req,
    nws_rsp_if.source                     o_rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [nws_pkg::ADDR_W-1:0]    paddr,
    input  logic [nws_pkg::PDATA_W-1:0]   pwdata,
    output logic [nws_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_SQ   = 6'b000010,
        S_SUM  = 6'b000100,
        S_FIRE = 6'b001000,
        S_WALK = 6'b010000,
        S_HOLD = 6'b100000
    } t_state;

    t_state                        r_state, n_state;
    logic [nws_pkg::PLEN_W-1:0]    r_path_len;
    nws_pkg::t_xyz                 r_pos;
    logic [nws_pkg::IDX_W-1:0]     r_pend_idx;
    logic                          r_pend_have;
    logic                          r_out_vld;
    logic [nws_pkg::IDX_W-1:0]     r_out_idx;
    logic                          r_out_found;
    logic                          w_acc;
    logic                          w_out_free;
    logic                          w_cfg_wr;
    nws_pkg::t_wr                  w_wr;
    nws_pkg::t_tok                 w_tok [0:MAX_WAYPOINTS];
    logic [MAX_WAYPOINTS:0]        w_tok_vld;

    // Handshake
    assign i_req.ready = (r_state == S_IDLE);
    assign w_acc       = i_req.valid && i_req.ready;
    assign w_out_free  = !r_out_vld || o_rsp.ready;

    // Configuration port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign prdata   = (paddr[2] == nws_pkg::REG_PATH_LEN)
                      ? {{(nws_pkg::PDATA_W - nws_pkg::PLEN_W){1'b0}}, r_path_len}
                      : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_path_len <= '0;
        end else if (w_cfg_wr && (paddr[2] == nws_pkg::REG_PATH_LEN)) begin
            r_path_len <= pwdata[nws_pkg::PLEN_W-1:0];
        end
    end

    // Write broadcast to the cells
    assign w_wr.en     = w_acc && (i_req.cmd == nws_pkg::CMD_WRITE);
    assign w_wr.idx    = i_req.entry_index;
    assign w_wr.pt.x   = i_req.coord_x;
    assign w_wr.pt.y   = i_req.coord_y;
    assign w_wr.pt.z   = i_req.coord_z;

    // Query position
    always_ff @(posedge i_clk) begin
        if (w_acc && (i_req.cmd == nws_pkg::CMD_QUERY)) begin
            r_pos.x <= i_req.coord_x;
            r_pos.y <= i_req.coord_y;
            r_pos.z <= i_req.coord_z;
        end
    end

    // Token injected into the first cell
    assign w_tok[0].vld  = (r_state == S_FIRE);
    assign w_tok[0].have = 1'b0;
    assign w_tok[0].idx  = '0;
    assign w_tok[0].dsq  = '0;

    // Row of cells
    for (genvar g = 0; g < MAX_WAYPOINTS; g++) begin : g_cell
        nws_cell #(
            .ID (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_wr       (w_wr),
            .i_pos      (r_pos),
            .i_path_len (r_path_len),
            .i_tok      (w_tok[g]),
            .o_tok      (w_tok[g+1])
        );
    end

    for (genvar k = 0; k <= MAX_WAYPOINTS; k++) begin : g_vld
        assign w_tok_vld[k] = w_tok[k].vld;
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc && (i_req.cmd == nws_pkg::CMD_QUERY)) begin
                    n_state = S_SQ;
                end
            end
            S_SQ:   n_state = S_SUM;
            S_SUM:  n_state = S_FIRE;
            S_FIRE: n_state = S_WALK;
            S_WALK: begin
                if (w_tok[MAX_WAYPOINTS].vld) begin
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Result from the last cell
    always_ff @(posedge i_clk) begin
        if ((r_state == S_WALK) && w_tok[MAX_WAYPOINTS].vld) begin
            r_pend_idx  <= w_tok[MAX_WAYPOINTS].idx;
            r_pend_have <= w_tok[MAX_WAYPOINTS].have;
        end
    end

    // Response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if ((r_state == S_HOLD) && w_out_free) begin
            r_out_vld   <= 1'b1;
            r_out_idx   <= r_pend_have ? r_pend_idx : '0;
            r_out_found <= r_pend_have;
        end else if (o_rsp.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    assign o_rsp.valid         = r_out_vld;
    assign o_rsp.nearest_index = r_out_idx;
    assign o_rsp.found         = r_out_found;

    // Checks
    `NWS_ASSERT(a_one_token, i_clk, i_rst_n, $countones(w_tok_vld) <= 1, "more than one token")
    `NWS_ASSERT(a_tok_in_walk, i_clk, i_rst_n, w_tok[MAX_WAYPOINTS].vld |-> (r_state == S_WALK), "token left the row outside walk")
    `NWS_ASSERT(a_empty_none, i_clk, i_rst_n, ((r_state == S_HOLD) && (r_path_len == '0)) |-> !r_pend_have, "empty path gave a hit")
    `NWS_ASSERT(a_rsp_from_hold, i_clk, i_rst_n, $rose(r_out_vld) |-> $past(r_state == S_HOLD), "response without finished query")

endmodule
